>>> design/efi_e820_pkg.sv
// Package: shared constants, types and the EFI type classifier of the E820 region merger.
`default_nettype none
package efi_e820_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int PAGE_SHIFT  = 12;

    localparam logic [63:0] HOLE_LO = 64'h0000_0000_000A_0000;
    localparam logic [63:0] HOLE_HI = 64'h0000_0000_0010_0000;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_RAM  = 3'd1,
        KIND_RES  = 3'd2,
        KIND_ACPI = 3'd3,
        KIND_NVS  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_MERGE  = 2'd1,
        ACT_DROP   = 2'd2
    } t_action;

    // Map an EFI memory type to its E820 kind; unknown types give KIND_NONE
    function automatic t_kind classify(input logic [3:0] mem_type);
        t_kind k;
        unique case (mem_type) inside
            4'd1, 4'd2, 4'd3, 4'd4, 4'd7:                k = KIND_RAM;
            4'd0, 4'd5, 4'd6, 4'd8, 4'd11, 4'd12, 4'd13: k = KIND_RES;
            4'd9:                                        k = KIND_ACPI;
            4'd10:                                       k = KIND_NVS;
            default:                                     k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

>>> design/efi_to_e820_region_merger.sv
// Top level: EFI descriptor to E820 table region merger with split of the legacy hole.
// Path: an accepted descriptor is held in the region register, and each result in the result
// register; the second region of a split follows the first.
// Throughput: one descriptor per cycle while results are taken; a RAM split around the
// 640K-1M hole stalls input, as one region per cycle goes on to the merge stage.
// Reset: synchronous, active low; clears entry count, last entry state and valids.
`default_nettype none
module efi_to_e820_region_merger (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_first_of_map,
    input  wire logic [3:0]  i_mem_type,
    input  wire logic [63:0] i_phys_start,
    input  wire logic [51:0] i_num_pages,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_entry_index,
    output logic [63:0]      o_region_addr,
    output logic [63:0]      o_region_size,
    output logic [2:0]       o_region_kind,
    output logic [1:0]       o_action,
    output logic             o_last_of_run
);

    localparam int CW = efi_e820_pkg::CNT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(efi_e820_pkg::MAX_ENTRIES);

    // ---------------- region stage (input register) ----------------
    logic                      r_rv;
    logic                      r_first;
    logic                      r_a_valid, r_b_valid;
    logic [63:0]               r_a_start, r_a_size, r_a_end;
    logic [63:0]               r_b_size, r_b_end;
    efi_e820_pkg::t_kind       r_kind;

    logic                      n_a_valid, n_b_valid;
    logic [63:0]               n_a_start, n_a_size, n_a_end;
    logic [63:0]               n_b_size, n_b_end;
    efi_e820_pkg::t_kind       w_kind;
    logic [63:0]               w_size, w_end;
    logic                      w_accept;

    // Split the incoming descriptor into at most two regions
    always_comb begin
        w_kind    = efi_e820_pkg::classify(i_mem_type);
        w_size    = {i_num_pages, {efi_e820_pkg::PAGE_SHIFT{1'b0}}};
        w_end     = i_phys_start + w_size;
        n_a_valid = 1'b0;
        n_b_valid = 1'b0;
        n_a_start = i_phys_start;
        n_a_size  = w_size;
        n_a_end   = w_end;
        n_b_size  = w_end - efi_e820_pkg::HOLE_HI;
        n_b_end   = w_end;
        if (w_kind == efi_e820_pkg::KIND_RAM &&
            i_phys_start < efi_e820_pkg::HOLE_HI && w_end > efi_e820_pkg::HOLE_LO) begin
            n_a_valid = i_phys_start < efi_e820_pkg::HOLE_LO;
            n_a_size  = efi_e820_pkg::HOLE_LO - i_phys_start;
            n_a_end   = efi_e820_pkg::HOLE_LO;
            n_b_valid = w_end > efi_e820_pkg::HOLE_HI;
        end else if (w_kind != efi_e820_pkg::KIND_NONE) begin
            n_a_valid = 1'b1;
        end
    end

    // ---------------- merge stage ----------------
    logic [CW-1:0]             r_count;
    logic [63:0]               r_last_addr, r_last_size, r_last_end;
    efi_e820_pkg::t_kind       r_last_kind;

    logic                      r_ov;
    logic [7:0]                r_idx;
    logic [63:0]               r_oaddr, r_osize;
    efi_e820_pkg::t_kind       r_okind;
    efi_e820_pkg::t_action     r_oact;
    logic                      r_olast;

    logic                      w_out_free, w_has_reg, w_two, w_issue, w_done;
    logic [CW-1:0]             w_eff_cnt;
    logic [63:0]               w_cur_start, w_cur_size, w_cur_end;
    logic                      w_merge, w_append;
    logic [63:0]               w_merged_size, w_merged_end;

    // Pick the current region and decide merge, append or drop
    always_comb begin
        w_out_free    = !r_ov || i_out_ready;
        w_has_reg     = r_a_valid || r_b_valid;
        w_two         = r_a_valid && r_b_valid;
        w_issue       = r_rv && w_has_reg && w_out_free;
        w_done        = r_rv && (!w_has_reg || (w_out_free && !w_two));
        w_eff_cnt     = r_first ? '0 : r_count;
        w_cur_start   = r_a_valid ? r_a_start : efi_e820_pkg::HOLE_HI;
        w_cur_size    = r_a_valid ? r_a_size  : r_b_size;
        w_cur_end     = r_a_valid ? r_a_end   : r_b_end;
        w_merge       = (w_eff_cnt != '0) && (r_last_end == w_cur_start) &&
                        (r_last_kind == r_kind);
        w_append      = !w_merge && (w_eff_cnt < MAX_CNT);
        w_merged_size = r_last_size + w_cur_size;
        w_merged_end  = r_last_end + w_cur_size;
    end

    assign o_in_ready = !r_rv || w_done;
    assign w_accept   = i_in_valid && o_in_ready;

    // Control: region stage valid and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_accept) begin
                r_rv <= 1'b1;
            end else if (w_done) begin
                r_rv <= 1'b0;
            end
            if (w_issue) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Load the region register; drop region A once it has been issued
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first   <= i_first_of_map;
            r_kind    <= w_kind;
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
            r_a_start <= n_a_start;
            r_a_size  <= n_a_size;
            r_a_end   <= n_a_end;
            r_b_size  <= n_b_size;
            r_b_end   <= n_b_end;
        end else if (w_issue && w_two) begin
            r_a_valid <= 1'b0;
            r_first   <= 1'b0;
        end
    end

    // Update the table state: entry count and last entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last_addr <= '0;
            r_last_size <= '0;
            r_last_end  <= '0;
            r_last_kind <= efi_e820_pkg::KIND_NONE;
        end else if (w_issue) begin
            if (w_merge) begin
                r_count     <= w_eff_cnt;
                r_last_size <= w_merged_size;
                r_last_end  <= w_merged_end;
            end else if (w_append) begin
                r_count     <= w_eff_cnt + 1'b1;
                r_last_addr <= w_cur_start;
                r_last_size <= w_cur_size;
                r_last_end  <= w_cur_end;
                r_last_kind <= r_kind;
            end else begin
                r_count     <= w_eff_cnt;
            end
        end else if (w_done) begin
            // descriptor with no region still applies the map restart
            r_count <= w_eff_cnt;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_okind <= r_kind;
            r_olast <= !w_two;
            if (w_merge) begin
                r_idx   <= 8'(w_eff_cnt - 1'b1);
                r_oaddr <= r_last_addr;
                r_osize <= w_merged_size;
                r_oact  <= efi_e820_pkg::ACT_MERGE;
            end else begin
                r_idx   <= 8'(w_eff_cnt);
                r_oaddr <= w_cur_start;
                r_osize <= w_cur_size;
                r_oact  <= w_append ? efi_e820_pkg::ACT_APPEND : efi_e820_pkg::ACT_DROP;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_entry_index = r_idx;
    assign o_region_addr = r_oaddr;
    assign o_region_size = r_osize;
    assign o_region_kind = r_okind;
    assign o_action      = r_oact;
    assign o_last_of_run = r_olast;

endmodule
`default_nettype wire

>>> design/efi_e820_checker.sv
// Checker: port-level assertions of the E820 region merger, bound to the top level.
`default_nettype none
module efi_e820_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_entry_index,
    input wire logic [63:0] o_region_addr,
    input wire logic [63:0] o_region_size,
    input wire logic [2:0]  o_region_kind,
    input wire logic [1:0]  o_action
);

    localparam logic [7:0] MAX_IDX = 8'(efi_e820_pkg::MAX_ENTRIES);

    // Hold a stalled result request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
        $stable(o_region_addr) && $stable(o_region_size) && $stable(o_entry_index))
        else $error("stalled result changed or vanished");

    // Drop only with a full table
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == efi_e820_pkg::ACT_DROP |-> o_entry_index == MAX_IDX)
        else $error("drop reported with table not full");

    // Append and merge address an entry inside the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action != efi_e820_pkg::ACT_DROP |-> o_entry_index < MAX_IDX)
        else $error("entry index beyond table");

    // Carry a real E820 kind
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_region_kind != efi_e820_pkg::KIND_NONE &&
        o_region_kind <= efi_e820_pkg::KIND_NVS)
        else $error("result kind out of range");

endmodule

bind efi_to_e820_region_merger efi_e820_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_entry_index (o_entry_index),
    .o_region_addr (o_region_addr),
    .o_region_size (o_region_size),
    .o_region_kind (o_region_kind),
    .o_action      (o_action)
);
`default_nettype wire

>>> dv/efi_to_e820_region_merger_tb.sv
// Testbench of the E820 region merger: directed and random requests against a predictor.
`timescale 1ns / 1ps
module efi_to_e820_region_merger_tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TOTAL_ITEMS  = 830;

    typedef struct packed {
        logic [7:0]            idx;
        logic [63:0]           addr;
        logic [63:0]           size;
        efi_e820_pkg::t_kind   kind;
        efi_e820_pkg::t_action act;
        logic                  last;
    } region_rec_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_first_of_map;
    logic [3:0]  i_mem_type;
    logic [63:0] i_phys_start;
    logic [51:0] i_num_pages;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_entry_index;
    logic [63:0] o_region_addr;
    logic [63:0] o_region_size;
    logic [2:0]  o_region_kind;
    logic [1:0]  o_action;
    logic        o_last_of_run;

    // Predicted table tail and pending regions
    logic [7:0]          tbl_count;
    logic [63:0]         tail_addr;
    logic [63:0]         tail_size;
    efi_e820_pkg::t_kind tail_kind;
    region_rec_t         expected_regions[$];

    int          mismatches;
    int          cycle_count;
    int          desc_sent;
    int          stall_left;
    bit          no_idle;

    efi_to_e820_region_merger dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_of_map (i_first_of_map),
        .i_mem_type     (i_mem_type),
        .i_phys_start   (i_phys_start),
        .i_num_pages    (i_num_pages),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_entry_index  (o_entry_index),
        .o_region_addr  (o_region_addr),
        .o_region_size  (o_region_size),
        .o_region_kind  (o_region_kind),
        .o_action       (o_action),
        .o_last_of_run  (o_last_of_run)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Pick an idle length: mostly none, sometimes short, rarely long
    function automatic int idle_len();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Stall the result side at random
    always @(posedge i_clk) begin : out_ready_gen
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left = idle_len();
        end
    end

    // EFI memory type to E820 kind
    function automatic efi_e820_pkg::t_kind efi_kind(input logic [3:0] typ);
        case (typ) inside
            4'd1, 4'd2, 4'd3, 4'd4, 4'd7:                return efi_e820_pkg::KIND_RAM;
            4'd0, 4'd5, 4'd6, 4'd8, 4'd11, 4'd12, 4'd13: return efi_e820_pkg::KIND_RES;
            4'd9:                                        return efi_e820_pkg::KIND_ACPI;
            4'd10:                                       return efi_e820_pkg::KIND_NVS;
            default:                                     return efi_e820_pkg::KIND_NONE;
        endcase
    endfunction

    // Merge a region into the tail entry, append it, or drop it when full
    function automatic region_rec_t fold_region(input logic [63:0] start,
                                                input logic [63:0] size,
                                                input efi_e820_pkg::t_kind kind);
        region_rec_t r;
        r.kind = kind;
        r.last = 1'b0;
        if (tbl_count != 0 && tail_addr + tail_size == start && tail_kind == kind) begin
            tail_size = tail_size + size;
            r.idx  = tbl_count - 8'd1;
            r.addr = tail_addr;
            r.size = tail_size;
            r.act  = efi_e820_pkg::ACT_MERGE;
        end else if (tbl_count < efi_e820_pkg::MAX_ENTRIES) begin
            tail_addr = start;
            tail_size = size;
            tail_kind = kind;
            r.idx  = tbl_count;
            r.addr = start;
            r.size = size;
            r.act  = efi_e820_pkg::ACT_APPEND;
            tbl_count++;
        end else begin
            r.idx  = tbl_count;
            r.addr = start;
            r.size = size;
            r.act  = efi_e820_pkg::ACT_DROP;
        end
        return r;
    endfunction

    // Work out the regions that one accepted descriptor yields
    function automatic void predict_regions(input logic first, input logic [3:0] typ,
                                            input logic [63:0] start,
                                            input logic [51:0] pages);
        region_rec_t         found[$];
        logic [63:0]         size;
        logic [63:0]         stop;
        efi_e820_pkg::t_kind kind;
        size = {pages, 12'h000};
        if (first) tbl_count = 8'd0;
        kind = efi_kind(typ);
        if (kind == efi_e820_pkg::KIND_NONE) return;
        stop = start + size;
        // Split usable RAM around the legacy hole, using the wrapped end
        if (kind == efi_e820_pkg::KIND_RAM && start < efi_e820_pkg::HOLE_HI &&
            stop > efi_e820_pkg::HOLE_LO) begin
            if (start < efi_e820_pkg::HOLE_LO)
                found.push_back(fold_region(start, efi_e820_pkg::HOLE_LO - start,
                                            efi_e820_pkg::KIND_RAM));
            if (stop > efi_e820_pkg::HOLE_HI)
                found.push_back(fold_region(efi_e820_pkg::HOLE_HI,
                                            stop - efi_e820_pkg::HOLE_HI,
                                            efi_e820_pkg::KIND_RAM));
        end else begin
            found.push_back(fold_region(start, size, kind));
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[i]) expected_regions.push_back(found[i]);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Compare each accepted result with the oldest expected region
    always @(posedge i_clk) begin : result_check
        region_rec_t exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_regions.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual idx=%0d addr=0x%0h",
                         $time, o_entry_index, o_region_addr);
                mismatches++;
            end else begin
                exp_r = expected_regions.pop_front();
                check_field("entry_index", exp_r.idx, o_entry_index);
                check_field("region_addr", exp_r.addr, o_region_addr);
                check_field("region_size", exp_r.size, o_region_size);
                check_field("region_kind", exp_r.kind, o_region_kind);
                check_field("action", exp_r.act, o_action);
                check_field("last_of_run", exp_r.last, o_last_of_run);
            end
        end
    end

    // Send one descriptor request and hold it until accepted
    task automatic send_desc(input logic first, input logic [3:0] typ,
                             input logic [63:0] start, input logic [51:0] pages);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_first_of_map <= first;
        i_mem_type     <= typ;
        i_phys_start   <= start;
        i_num_pages    <= pages;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_regions(first, typ, start, pages);
        desc_sent++;
    endtask

    // Hold requests until every expected region has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_regions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [3:0] pick_type();
        logic [3:0] ram_types[5] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd7};
        if ($urandom_range(0, 1) == 0) return ram_types[$urandom_range(0, 4)];
        return 4'($urandom_range(0, 15));
    endfunction

    // Send a descriptor of a well-formed map, mostly contiguous with the last one
    task automatic send_map_item(input logic first, inout logic [63:0] cursor);
        logic [3:0]  typ;
        logic [51:0] pages;
        logic [63:0] start;
        int          roll;
        roll  = $urandom_range(0, 99);
        typ   = pick_type();
        pages = 52'($urandom_range(0, 48));
        if (roll < 70)      start = cursor;
        else if (roll < 85) start = cursor + 64'($urandom_range(1, 16) << 12);
        else if (roll < 95) start = 64'($urandom_range(0, 'h120) << 12);
        else                start = {$urandom, $urandom};
        if ($urandom_range(0, 19) == 0) pages = 52'({$urandom, $urandom});
        send_desc(first, typ, start, pages);
        cursor = start + {pages, 12'h000};
    endtask

    task automatic send_noise();
        send_desc(1'($urandom), 4'($urandom), {$urandom, $urandom}, 52'({$urandom, $urandom}));
    endtask

    // Extremes, every type, hole splits, wrap and empty table
    task automatic test_directed();
        logic [63:0] cursor;
        logic [3:0]  walk_types[9] = '{4'd6, 4'd8, 4'd11, 4'd12, 4'd13,
                                       4'd9, 4'd9, 4'd10, 4'd10};
        // Zero-size region into an empty table, then merge into it
        send_desc(1'b1, 4'd0, 64'h0, 52'h0);
        send_desc(1'b0, 4'd5, 64'h0, 52'h1);
        // RAM ending right at the hole, inside the hole, across and partly over it
        send_desc(1'b0, 4'd1, 64'h1000, 52'h9F);
        send_desc(1'b0, 4'd2, 64'hA0000, 52'h10);
        send_desc(1'b0, 4'd3, 64'h90000, 52'h170);
        send_desc(1'b0, 4'd4, 64'h0, 52'hC0);
        send_desc(1'b0, 4'd7, 64'hB0000, 52'hD0);
        send_desc(1'b0, 4'd1, 64'hFF000, 52'h2);
        // Walk the remaining known types over contiguous addresses
        cursor = 64'h200000;
        foreach (walk_types[i]) begin
            send_desc(1'b0, walk_types[i], cursor, 52'h4);
            cursor = cursor + 64'h4000;
        end
        // Unknown types are ignored, but a new map still clears the table
        send_desc(1'b0, 4'd15, cursor, 52'h1);
        send_desc(1'b1, 4'd14, 64'h5000, 52'h1);
        // Wrapping RAM regions: whole below the hole, and wrapped into the hole
        send_desc(1'b0, 4'd7, 64'h5000, {52{1'b1}});
        send_desc(1'b0, 4'd7, 64'hFF000, {52{1'b1}});
        // All-ones fields
        send_desc(1'b0, 4'd13, {64{1'b1}}, {52{1'b1}});
        send_desc(1'b1, 4'd1, {64{1'b1}}, {52{1'b1}});
        drain_results();
    endtask

    // Fill the table, drop past the end, then merge into the full table
    task automatic test_table_full();
        logic [63:0] cursor;
        logic [51:0] pages;
        cursor = 64'h1_0000_0000;
        send_desc(1'b1, 4'd0, cursor, 52'h1);
        cursor = cursor + 64'h1000;
        for (int i = 1; i < efi_e820_pkg::MAX_ENTRIES + 4; i++) begin
            pages = 52'($urandom_range(0, 8));
            send_desc(1'b0, (i % 2 == 1) ? 4'd9 : 4'd0, cursor, pages);
            cursor = cursor + {pages, 12'h000};
        end
        send_desc(1'b0, 4'd10, {$urandom, $urandom}, 52'($urandom));
        send_desc(1'b0, 4'd8, cursor, 52'h3);
        // Extend the last entry of the full table
        send_desc(1'b0, (tail_kind == efi_e820_pkg::KIND_ACPI) ? 4'd9 : 4'd0,
                  tail_addr + tail_size, 52'h3);
        drain_results();
    endtask

    // Let every expected region out before sending more
    task automatic test_drain_pause();
        logic [63:0] cursor;
        cursor = 64'h0;
        for (int i = 0; i < 20; i++) send_map_item(i == 0, cursor);
        drain_results();
        for (int i = 0; i < 20; i++) send_map_item(1'b0, cursor);
        drain_results();
    endtask

    // Run requests back to back with no idling on either side
    task automatic test_back_to_back();
        logic [63:0] cursor;
        cursor = 64'h80000;
        no_idle = 1'b1;
        for (int i = 0; i < 60; i++) begin
            if (i % 15 == 7) send_noise();
            else send_map_item(i == 0, cursor);
        end
        drain_results();
        no_idle = 1'b0;
    endtask

    // Random maps of random length, with noise and broken maps mixed in
    task automatic test_random_maps();
        logic [63:0] cursor;
        int          map_len;
        while (desc_sent < TOTAL_ITEMS) begin
            cursor  = 64'($urandom_range(0, 'h200) << 12);
            map_len = ($urandom_range(0, 11) == 0) ? $urandom_range(120, 150)
                                                   : $urandom_range(1, 30);
            for (int i = 0; i < map_len; i++) begin
                if ($urandom_range(0, 99) < 12) send_noise();
                else send_map_item(i == 0 || $urandom_range(0, 49) == 0, cursor);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_first_of_map = 1'b0;
        i_mem_type     = 4'd0;
        i_phys_start   = 64'h0;
        i_num_pages    = 52'h0;
        i_out_ready    = 1'b0;
        tbl_count      = 8'd0;
        tail_addr      = 64'h0;
        tail_size      = 64'h0;
        tail_kind      = efi_e820_pkg::KIND_NONE;
        mismatches     = 0;
        cycle_count    = 0;
        desc_sent      = 0;
        stall_left     = 0;
        no_idle        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_drain_pause();
        test_back_to_back();
        test_random_maps();

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
